/* src/mtm_pkg.sv */
package mtm_pkg;

	// Channel count of the score and volume reset value
	localparam int unsigned NUM_CHANNELS = 16;
	localparam logic [7:0]  VOL_RESET    = 8'd64;

	// Parser phase
	typedef enum logic [2:0] {
		PH_DESC  = 3'd0,
		PH_NOTE  = 3'd1,
		PH_VOL   = 3'd2,
		PH_CNUM  = 3'd3,
		PH_CVAL  = 3'd4,
		PH_PITCH = 3'd5,
		PH_SYS   = 3'd6,
		PH_DELAY = 3'd7
	} mtm_phase_t;

	// Result kinds
	localparam logic [1:0] KIND_MIDI  = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// MUS event types
	localparam logic [2:0] TYPE_RELEASE = 3'd0;
	localparam logic [2:0] TYPE_PLAY    = 3'd1;
	localparam logic [2:0] TYPE_PITCH   = 3'd2;
	localparam logic [2:0] TYPE_SYS     = 3'd3;
	localparam logic [2:0] TYPE_CTRL    = 3'd4;
	localparam logic [2:0] TYPE_END     = 3'd6;

	// MIDI status types
	localparam logic [7:0] MIDI_NOTE_OFF = 8'h80;
	localparam logic [7:0] MIDI_NOTE_ON  = 8'h90;
	localparam logic [7:0] MIDI_CTRL     = 8'hb0;
	localparam logic [7:0] MIDI_PROGRAM  = 8'hc0;
	localparam logic [7:0] MIDI_PITCH    = 8'he0;

	localparam logic [3:0] CH_DRUM_MUS  = 4'd15;
	localparam logic [3:0] CH_DRUM_MIDI = 4'd9;
	localparam logic [7:0] VEL_MAX      = 8'd127;

	// One result item
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] delta;
		logic [7:0]  status;
		logic [7:0]  d1;
		logic [7:0]  d2;
	} mtm_result_t;

	// MUS controller number to MIDI controller number
	function automatic logic [7:0] map_ctrl(input logic [7:0] n);
		logic [7:0] m;
		begin
			case (n)
				8'd0:  m = 8'd0;
				8'd1:  m = 8'd0;
				8'd2:  m = 8'd1;
				8'd3:  m = 8'd7;
				8'd4:  m = 8'd10;
				8'd5:  m = 8'd11;
				8'd6:  m = 8'd91;
				8'd7:  m = 8'd93;
				8'd8:  m = 8'd64;
				8'd9:  m = 8'd67;
				8'd10: m = 8'd120;
				8'd11: m = 8'd123;
				8'd12: m = 8'd126;
				8'd13: m = 8'd127;
				8'd14: m = 8'd121;
				default: m = 8'd0;
			endcase
			return m;
		end
	endfunction

	// Swap MUS percussion channel with MIDI percussion channel
	function automatic logic [3:0] remap_ch(input logic [3:0] ch);
		logic [3:0] r;
		begin
			if (ch == CH_DRUM_MUS) begin
				r = CH_DRUM_MIDI;
			end else if (ch == CH_DRUM_MIDI) begin
				r = CH_DRUM_MUS;
			end else begin
				r = ch;
			end
			return r;
		end
	endfunction

endpackage

/* src/mtm_vol_table.sv */
module mtm_vol_table #(
	parameter int unsigned NumCh = mtm_pkg::NUM_CHANNELS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [$clog2(NumCh)-1:0] wr_addr,
	input  logic [7:0]               wr_data,
	input  logic [$clog2(NumCh)-1:0] rd_addr,
	output logic [7:0]               rd_data
);
	import mtm_pkg::*;

	logic [7:0] vol_q [NumCh];

	// Per-channel volume, reset to default level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumCh; i++) begin
				vol_q[i] <= VOL_RESET;
			end
		end else if (wr_en) begin
			vol_q[wr_addr] <= wr_data;
		end
	end

	assign rd_data = vol_q[rd_addr];

endmodule

/* src/mtm_parser.sv */
module mtm_parser #(
	parameter int unsigned NumCh = mtm_pkg::NUM_CHANNELS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           mus_byte,
	input  logic                 start_of_score,
	input  logic                 volume_shift,
	output logic                 res_valid,
	output mtm_pkg::mtm_result_t res
);
	import mtm_pkg::*;

	localparam int unsigned IdxW = $clog2(NumCh);

	mtm_phase_t  phase_q, phase_d;
	logic [2:0]  event_type_q, event_type_d;
	logic [3:0]  event_channel_q, event_channel_d;
	logic        group_last_q, group_last_d;
	logic [7:0]  first_param_q, first_param_d;
	logic [31:0] pending_delay_q, pending_delay_d;
	logic        halted_q, halted_d;

	logic        vol_wr;
	logic [7:0]  vol_rd;
	logic [7:0]  vol_cur;
	logic [8:0]  vol_shifted;
	logic [7:0]  velocity;
	mtm_phase_t  ph_eff;
	logic [31:0] pd_eff;
	logic        halt_eff;
	logic [7:0]  status_ch;
	mtm_phase_t  after_emit;

	mtm_vol_table #(.NumCh(NumCh)) u_vol (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (vol_wr),
		.wr_addr (event_channel_q[IdxW-1:0]),
		.wr_data (mus_byte),
		.rd_addr (event_channel_q[IdxW-1:0]),
		.rd_data (vol_rd)
	);

	// Velocity: new volume byte bypasses the table, shift and saturate
	always_comb begin
		vol_cur     = (phase_q == PH_VOL) ? mus_byte : vol_rd;
		vol_shifted = volume_shift ? {vol_cur, 1'b0} : {1'b0, vol_cur};
		velocity    = (vol_shifted > {1'b0, VEL_MAX}) ? VEL_MAX : vol_shifted[7:0];
	end

	assign status_ch  = {4'd0, remap_ch(event_channel_q)};
	assign after_emit = group_last_q ? PH_DELAY : PH_DESC;

	// Parser step for one item
	always_comb begin
		ph_eff   = start_of_score ? PH_DESC : phase_q;
		pd_eff   = start_of_score ? 32'd0 : pending_delay_q;
		halt_eff = start_of_score ? 1'b0 : halted_q;

		phase_d         = ph_eff;
		event_type_d    = event_type_q;
		event_channel_d = event_channel_q;
		group_last_d    = group_last_q;
		first_param_d   = first_param_q;
		pending_delay_d = pd_eff;
		halted_d        = halt_eff;
		vol_wr          = 1'b0;
		res_valid       = 1'b0;
		res.kind        = KIND_MIDI;
		res.delta       = pd_eff;
		res.status      = 8'd0;
		res.d1          = 8'd0;
		res.d2          = 8'd0;

		if (!halt_eff) begin
			case (ph_eff)
				PH_DESC: begin
					event_channel_d = mus_byte[3:0];
					event_type_d    = mus_byte[6:4];
					group_last_d    = mus_byte[7];
					case (mus_byte[6:4])
						TYPE_RELEASE, TYPE_PLAY: phase_d = PH_NOTE;
						TYPE_PITCH:              phase_d = PH_PITCH;
						TYPE_SYS:                phase_d = PH_SYS;
						TYPE_CTRL:               phase_d = PH_CNUM;
						TYPE_END: begin
							halted_d  = 1'b1;
							phase_d   = PH_DESC;
							res_valid = 1'b1;
							res.kind  = KIND_END;
						end
						default: begin
							halted_d  = 1'b1;
							phase_d   = PH_DESC;
							res_valid = 1'b1;
							res.kind  = KIND_ERROR;
						end
					endcase
				end
				PH_NOTE: begin
					if (event_type_q == TYPE_RELEASE) begin
						res_valid  = 1'b1;
						res.status = MIDI_NOTE_OFF | status_ch;
						res.d1     = mus_byte;
					end else begin
						first_param_d = mus_byte;
						if (mus_byte[7]) begin
							phase_d = PH_VOL;
						end else begin
							res_valid  = 1'b1;
							res.status = MIDI_NOTE_ON | status_ch;
							res.d1     = {1'b0, mus_byte[6:0]};
							res.d2     = velocity;
						end
					end
				end
				PH_VOL: begin
					vol_wr     = 1'b1;
					res_valid  = 1'b1;
					res.status = MIDI_NOTE_ON | status_ch;
					res.d1     = {1'b0, first_param_q[6:0]};
					res.d2     = velocity;
				end
				PH_CNUM: begin
					first_param_d = mus_byte;
					phase_d       = PH_CVAL;
				end
				PH_CVAL: begin
					res_valid = 1'b1;
					if (first_param_q == 8'd0) begin
						res.status = MIDI_PROGRAM | status_ch;
						res.d1     = mus_byte;
					end else begin
						res.status = MIDI_CTRL | status_ch;
						res.d1     = map_ctrl(first_param_q);
						res.d2     = mus_byte;
					end
				end
				PH_PITCH: begin
					res_valid  = 1'b1;
					res.status = MIDI_PITCH | status_ch;
					res.d1     = {1'b0, mus_byte[0], 6'd0};
					res.d2     = {1'b0, mus_byte[7:1]};
				end
				PH_SYS: begin
					res_valid  = 1'b1;
					res.status = MIDI_CTRL | status_ch;
					res.d1     = map_ctrl(mus_byte);
				end
				PH_DELAY: begin
					pending_delay_d = {pd_eff[24:0], mus_byte[6:0]};
					if (!mus_byte[7]) begin
						phase_d = PH_DESC;
					end
				end
				default: phase_d = PH_DESC;
			endcase

			// MIDI events return to descriptor or delay, every result clears delay
			if (res_valid) begin
				pending_delay_d = 32'd0;
				if (res.kind == KIND_MIDI) begin
					phase_d = after_emit;
				end
			end
		end

		// Volume write only on a real step
		vol_wr = vol_wr && step;
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_DESC;
			event_type_q    <= 3'd0;
			event_channel_q <= 4'd0;
			group_last_q    <= 1'b0;
			first_param_q   <= 8'd0;
			pending_delay_q <= 32'd0;
			halted_q        <= 1'b0;
		end else if (step) begin
			phase_q         <= phase_d;
			event_type_q    <= event_type_d;
			event_channel_q <= event_channel_d;
			group_last_q    <= group_last_d;
			first_param_q   <= first_param_d;
			pending_delay_q <= pending_delay_d;
			halted_q        <= halted_d;
		end
	end

endmodule

/* src/mus_to_midi_event_converter_top.sv */
// MUS to MIDI event converter, one score byte per item.
// Path: an accepted byte waits in the input register, and the parser pass on
// it loads the output register once that register is free or being emptied.
// Throughput: one byte per cycle while the output is not stalled, set by the single parser pass per byte.
// Reset: parser idle waiting for a descriptor, delay cleared, all channel
// volumes 64, volume shift 0.
module mus_to_midi_event_converter_top #(
	parameter int unsigned NUM_CHANNELS = mtm_pkg::NUM_CHANNELS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  mus_byte,
	input  logic        start_of_score,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [31:0] delta_ticks,
	output logic [7:0]  status_byte,
	output logic [7:0]  data_one,
	output logic [7:0]  data_two
);
	import mtm_pkg::*;

	logic        volume_shift_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;
	logic        advance;
	logic        in_take;
	logic        res_valid;
	mtm_result_t res;
	mtm_result_t res_q;
	logic        out_valid_q;

	assign cfg_ready = 1'b1;

	// Volume shift register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_shift_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			volume_shift_q <= cfg_data;
		end
	end

	// Held byte moves on when the output register is free or being emptied
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1  <= mus_byte;
			start_s1 <= start_of_score;
		end
	end

	mtm_parser #(.NumCh(NUM_CHANNELS)) u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.mus_byte       (byte_s1),
		.start_of_score (start_s1),
		.volume_shift   (volume_shift_q),
		.res_valid      (res_valid),
		.res            (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = res_q.kind;
	assign delta_ticks = res_q.delta;
	assign status_byte = res_q.status;
	assign data_one    = res_q.d1;
	assign data_two    = res_q.d2;

endmodule

/* sim/tb_mus_to_midi_event_converter_top.sv */
`timescale 1ns / 100ps

module tb_mus_to_midi_event_converter_top;
	import mtm_pkg::*;

	// Event type codes the block must reject
	localparam logic [2:0] TYPE_UNDEF_A = 3'd5;
	localparam logic [2:0] TYPE_UNDEF_B = 3'd7;

	// Cycles to let the two-stage pipe empty after the last expected result
	localparam int SETTLE_CYCLES = 6;
	// Cycles without any handshake before the run is declared hung
	localparam int QUIET_LIMIT = 2000;
	// Random bytes per configuration phase
	localparam int PHASE_BYTES = 410;

	// Tracks the converter state and holds the MIDI events still to come out
	class midi_event_tracker;
		mtm_phase_t  phase;
		logic [2:0]  ev_type;
		logic [3:0]  ev_chan;
		logic        ev_last;
		logic [7:0]  held_param;
		logic [7:0]  chan_vol [16];
		logic [31:0] ticks;
		bit          halted;
		bit          vol_shift;
		logic [7:0]  ctl_table [15];
		mtm_result_t expected_events [$];
		int unsigned fail_count;

		function new();
			phase = PH_DESC;
			ev_type = 3'd0;
			ev_chan = 4'd0;
			ev_last = 1'b0;
			held_param = 8'd0;
			foreach (chan_vol[i]) chan_vol[i] = 8'd64;
			ticks = 32'd0;
			halted = 0;
			vol_shift = 0;
			ctl_table = '{8'd0, 8'd0, 8'd1, 8'd7, 8'd10, 8'd11, 8'd91, 8'd93,
				8'd64, 8'd67, 8'd120, 8'd123, 8'd126, 8'd127, 8'd121};
			fail_count = 0;
		endfunction

		function void set_shift(bit v);
			vol_shift = v;
		endfunction

		function logic [7:0] ctl_number(logic [7:0] n);
			return (n < 8'd15) ? ctl_table[n] : 8'd0;
		endfunction

		function logic [7:0] note_velocity();
			logic [8:0] v;
			v = {1'b0, chan_vol[ev_chan]} << vol_shift;
			return (v > 9'd127) ? VEL_MAX : v[7:0];
		endfunction

		// Every result carries the pending delay and clears it
		function void push_event(logic [1:0] kind, logic [7:0] status,
				logic [7:0] d1, logic [7:0] d2);
			mtm_result_t r;
			r.kind = kind;
			r.delta = ticks;
			r.status = status;
			r.d1 = d1;
			r.d2 = d2;
			ticks = 32'd0;
			expected_events.push_back(r);
		endfunction

		// MIDI event with percussion channel swap
		function void push_midi(logic [7:0] msg, logic [7:0] d1, logic [7:0] d2);
			logic [3:0] ch;
			ch = ev_chan;
			if (ch == 4'd15) ch = 4'd9;
			else if (ch == 4'd9) ch = 4'd15;
			phase = ev_last ? PH_DELAY : PH_DESC;
			push_event(KIND_MIDI, msg | {4'h0, ch}, d1, d2);
		endfunction

		// One accepted score byte
		function void take_byte(logic [7:0] b, logic sos);
			logic [13:0] bend;
			if (sos) begin
				phase = PH_DESC;
				ticks = 32'd0;
				halted = 0;
			end
			if (halted) return;
			case (phase)
				PH_DESC: begin
					ev_chan = b[3:0];
					ev_type = b[6:4];
					ev_last = b[7];
					case (ev_type)
						TYPE_RELEASE, TYPE_PLAY: phase = PH_NOTE;
						TYPE_PITCH: phase = PH_PITCH;
						TYPE_SYS: phase = PH_SYS;
						TYPE_CTRL: phase = PH_CNUM;
						TYPE_END: begin
							halted = 1;
							push_event(KIND_END, 8'd0, 8'd0, 8'd0);
						end
						default: begin
							halted = 1;
							push_event(KIND_ERROR, 8'd0, 8'd0, 8'd0);
						end
					endcase
				end
				PH_NOTE: begin
					if (ev_type == TYPE_RELEASE) begin
						push_midi(MIDI_NOTE_OFF, b, 8'd0);
					end else begin
						held_param = b;
						// note byte with bit 7 set: a volume byte follows
						if (b[7]) phase = PH_VOL;
						else push_midi(MIDI_NOTE_ON, {1'b0, b[6:0]}, note_velocity());
					end
				end
				PH_VOL: begin
					chan_vol[ev_chan] = b;
					push_midi(MIDI_NOTE_ON, {1'b0, held_param[6:0]}, note_velocity());
				end
				PH_CNUM: begin
					held_param = b;
					phase = PH_CVAL;
				end
				PH_CVAL: begin
					// controller zero is an instrument change
					if (held_param == 8'd0) push_midi(MIDI_PROGRAM, b, 8'd0);
					else push_midi(MIDI_CTRL, ctl_number(held_param), b);
				end
				PH_PITCH: begin
					bend = {b, 6'b0};
					push_midi(MIDI_PITCH, {1'b0, bend[6:0]}, {1'b0, bend[13:7]});
				end
				PH_SYS: push_midi(MIDI_CTRL, ctl_number(b), 8'd0);
				default: begin
					ticks = {ticks[24:0], b[6:0]};
					if (!b[7]) phase = PH_DESC;
				end
			endcase
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s expected 0x%0h actual 0x%0h", name, want, got);
				fail_count++;
			end
		endfunction

		function void check_event(mtm_result_t got);
			mtm_result_t want;
			if (expected_events.size() == 0) begin
				$error("unexpected result: kind %0d delta 0x%0h status 0x%0h",
					got.kind, got.delta, got.status);
				fail_count++;
				return;
			end
			want = expected_events.pop_front();
			compare_field("result_kind", {30'd0, want.kind}, {30'd0, got.kind});
			compare_field("delta_ticks", want.delta, got.delta);
			compare_field("status_byte", {24'd0, want.status}, {24'd0, got.status});
			compare_field("data_one", {24'd0, want.d1}, {24'd0, got.d1});
			compare_field("data_two", {24'd0, want.d2}, {24'd0, got.d2});
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  mus_byte;
	logic        start_of_score;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  result_kind;
	logic [31:0] delta_ticks;
	logic [7:0]  status_byte;
	logic [7:0]  data_one;
	logic [7:0]  data_two;

	midi_event_tracker tracker;
	bit calm;
	int bytes_sent;

	mus_to_midi_event_converter_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mus_byte       (mus_byte),
		.start_of_score (start_of_score),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_kind    (result_kind),
		.delta_ticks    (delta_ticks),
		.status_byte    (status_byte),
		.data_one       (data_one),
		.data_two       (data_two)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Idle with a chance of about 8 in 100 per draw, never during a calm stretch
	function automatic bit roll_idle();
		return !calm && ($urandom_range(99) < 8);
	endfunction

	// Offer one score byte and hold it until accepted
	task automatic send_byte(input logic [7:0] b, input logic sos);
		@(negedge clk);
		while (roll_idle()) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mus_byte <= b;
		start_of_score <= sos;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		tracker.take_byte(b, sos);
		bytes_sent++;
	endtask

	// Descriptor plus its parameter bytes
	task automatic send_event(input logic [2:0] typ, input logic [3:0] ch, input logic last,
			input logic [7:0] p1, input logic [7:0] p2, input logic sos);
		send_byte({last, typ, ch}, sos);
		case (typ)
			TYPE_RELEASE, TYPE_PITCH, TYPE_SYS: send_byte(p1, 1'b0);
			TYPE_PLAY: begin
				send_byte(p1, 1'b0);
				if (p1[7]) send_byte(p2, 1'b0);
			end
			TYPE_CTRL: begin
				send_byte(p1, 1'b0);
				send_byte(p2, 1'b0);
			end
			default: ;
		endcase
	endtask

	// Variable-length delay, mostly short, sometimes long enough to wrap
	task automatic send_delay();
		int pick;
		int n;
		logic [7:0] b;
		pick = $urandom_range(99);
		n = (pick < 60) ? 1 : (pick < 85) ? 2 : (pick < 95) ? 3 : $urandom_range(5, 4);
		for (int j = 0; j < n; j++) begin
			b = 8'($urandom_range(255));
			b[7] = (j < n - 1);
			send_byte(b, 1'b0);
		end
	endtask

	// Random bytes, rarely with a score start among them
	task automatic send_noise();
		int n;
		n = $urandom_range(6, 1);
		for (int k = 0; k < n; k++)
			send_byte(8'($urandom_range(255)), $urandom_range(99) < 10);
	endtask

	// One well-formed score with random content and a random ending
	task automatic random_score();
		int n_ev;
		int pick;
		logic [2:0] typ;
		logic [3:0] ch;
		logic last;
		logic [7:0] p1;
		logic [7:0] p2;
		n_ev = $urandom_range(12, 1);
		for (int i = 0; i < n_ev; i++) begin
			pick = $urandom_range(99);
			typ = (pick < 30) ? TYPE_PLAY : (pick < 50) ? TYPE_RELEASE :
				(pick < 70) ? TYPE_CTRL : (pick < 85) ? TYPE_PITCH : TYPE_SYS;
			ch = 4'($urandom_range(15));
			last = ($urandom_range(99) < 40);
			p1 = 8'($urandom_range(255));
			p2 = 8'($urandom_range(255));
			if ((typ == TYPE_CTRL || typ == TYPE_SYS) && $urandom_range(99) < 85)
				p1 = 8'($urandom_range(14));
			// a descriptor cut short by the next score
			if (i > 0 && $urandom_range(99) < 3) begin
				send_byte({last, typ, ch}, 1'b0);
				return;
			end
			send_event(typ, ch, last, p1, p2, i == 0);
			if (last) send_delay();
		end
		pick = $urandom_range(99);
		if (pick < 78) begin
			send_event(TYPE_END, 4'($urandom_range(15)), 1'($urandom_range(1)),
				8'd0, 8'd0, 1'b0);
		end else if (pick < 88) begin
			send_event($urandom_range(1) ? TYPE_UNDEF_A : TYPE_UNDEF_B,
				4'($urandom_range(15)), 1'($urandom_range(1)), 8'd0, 8'd0, 1'b0);
		end else if (pick < 94) begin
			send_noise();
		end
		// bytes after the halt are dropped
		if (pick < 88 && $urandom_range(99) < 20) send_noise();
	endtask

	// Stop sending until every expected result is out and the pipe is empty
	task automatic wait_all_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.expected_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_shift(input logic v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tracker.set_shift(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Result side: random stalls, check every accepted item
	initial begin
		mtm_result_t got;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got.kind = result_kind;
				got.delta = delta_ticks;
				got.status = status_byte;
				got.d1 = data_one;
				got.d2 = data_two;
				tracker.check_event(got);
			end
			@(negedge clk);
			out_stall <= roll_idle();
		end
	end

	// Hang detection: cycles without any handshake
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("mus_to_midi_event_converter_top test failed");
		$finish;
	end

	// Stimulus
	initial begin
		int phase_end;
		bit paused;
		in_valid = 1'b0;
		mus_byte = 8'd0;
		start_of_score = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		calm = 0;
		paused = 0;
		bytes_sent = 0;
		tracker = new();
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed, no volume shift: extremes, all types, channel swap, wrap
		write_shift(1'b0);
		send_event(TYPE_PLAY, 4'd0, 1'b0, 8'h3c, 8'h00, 1'b1);
		send_event(TYPE_PLAY, 4'd15, 1'b1, 8'hff, 8'hff, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h7f, 1'b0);
		send_event(TYPE_RELEASE, 4'd9, 1'b0, 8'hff, 8'h00, 1'b0);
		send_event(TYPE_PITCH, 4'd1, 1'b0, 8'hff, 8'h00, 1'b0);
		send_event(TYPE_SYS, 4'd4, 1'b0, 8'hff, 8'h00, 1'b0);
		send_event(TYPE_CTRL, 4'd5, 1'b0, 8'h00, 8'hff, 1'b0);
		send_event(TYPE_CTRL, 4'd7, 1'b1, 8'd15, 8'h01, 1'b0);
		send_byte(8'h05, 1'b0);
		send_event(TYPE_END, 4'd0, 1'b1, 8'h00, 8'h00, 1'b0);
		send_byte(8'h90, 1'b0);
		send_event(TYPE_UNDEF_A, 4'd2, 1'b0, 8'h00, 8'h00, 1'b1);
		send_event(TYPE_UNDEF_B, 4'd15, 1'b1, 8'h00, 8'h00, 1'b1);
		wait_all_results();

		// Directed, doubled volume: saturation and just below it
		write_shift(1'b1);
		send_event(TYPE_PLAY, 4'd0, 1'b0, 8'h01, 8'h00, 1'b1);
		send_event(TYPE_PLAY, 4'd8, 1'b0, 8'h81, 8'h3f, 1'b0);
		send_event(TYPE_END, 4'd8, 1'b0, 8'h00, 8'h00, 1'b0);

		// Random scores in four settings; one calm phase, one mid-phase hold-off
		for (int ph = 0; ph < 4; ph++) begin
			wait_all_results();
			write_shift(1'(ph % 2));
			calm = (ph == 2);
			phase_end = bytes_sent + PHASE_BYTES;
			while (bytes_sent < phase_end) begin
				random_score();
				if (ph == 1 && !paused && bytes_sent > phase_end - PHASE_BYTES / 2) begin
					wait_all_results();
					paused = 1;
				end
			end
		end
		calm = 0;
		wait_all_results();

		if (tracker.fail_count == 0)
			$display("mus_to_midi_event_converter_top test passed");
		else
			$display("mus_to_midi_event_converter_top test failed");
		$finish;
	end

endmodule

/* filelist.f */
src/mtm_pkg.sv
src/mtm_vol_table.sv
src/mtm_parser.sv
src/mus_to_midi_event_converter_top.sv
sim/tb_mus_to_midi_event_converter_top.sv
